/* rtl/sjc_pkg.sv */
package sjc_pkg;

  localparam int RECORD_SLOTS_DEFAULT = 16;
  localparam int REC_BYTES = 12;
  localparam int MSG_W = REC_BYTES * 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] REC_MAGIC = 32'h5042_4646;
  localparam logic [31:0] REC_ERASED = 32'hFFFF_FFFF;
  localparam logic [7:0] REC_VERSION = 8'd1;

  localparam logic [7:0] FALLBACK_RESET = 8'd0;
  localparam logic [7:0] DEFAULT_RESET = 8'd0;
  localparam logic [7:0] MAX_PROFILE_RESET = 8'd15;
  localparam logic STORE_ENABLED_RESET = 1'b1;
  localparam logic [15:0] SAVE_DELAY_RESET = 16'd2000;

  typedef enum logic [1:0] {
    OP_SCAN     = 2'd0,
    OP_SET      = 2'd1,
    OP_TICK     = 2'd2,
    OP_READBACK = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FALLBACK      = 3'd0,
    REG_DEFAULT       = 3'd1,
    REG_MAX_PROFILE   = 3'd2,
    REG_STORE_ENABLED = 3'd3,
    REG_SAVE_DELAY    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] now_ms;
    logic [7:0]  requested_profile;
    logic [31:0] rec_magic;
    logic [31:0] rec_sequence;
    logic [7:0]  rec_version;
    logic [7:0]  rec_profile;
    logic [7:0]  rec_inverse;
    logic [7:0]  rec_reserved;
    logic [31:0] rec_checksum;
    logic        flash_ok;
  } item_t;

  typedef struct packed {
    logic [7:0]  current_profile;
    logic        save_pending;
    logic        record_valid;
    logic        write_request;
    logic [3:0]  write_slot;
    logic        write_erase;
    logic [31:0] write_sequence;
    logic [31:0] write_checksum;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fnv_status_t;

endpackage

/* rtl/sjc_fnv.sv */
module sjc_fnv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sjc_pkg::MSG_W-1:0]  msg,
  output logic [31:0]                hash,
  output sjc_pkg::fnv_status_t       status
);

  localparam int CW = $clog2(sjc_pkg::REC_BYTES);
  localparam logic [CW-1:0] LAST = CW'(sjc_pkg::REC_BYTES - 1);

  logic [sjc_pkg::MSG_W-1:0] shift;
  logic [CW-1:0] count;
  logic busy;
  logic [31:0] mixed;
  logic [31:0] hash_next;

  // one byte per cycle, low byte first
  assign mixed = hash ^ {24'd0, shift[7:0]};
  assign hash_next = mixed * sjc_pkg::FNV_PRIME;

  assign status.busy = busy;
  assign status.done = busy && (count == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + CW'(1);
      if (count == LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash <= sjc_pkg::FNV_BASIS;
      shift <= msg;
    end else if (busy) begin
      hash <= hash_next;
      shift <= {8'd0, shift[sjc_pkg::MSG_W-1:8]};
    end
  end

endmodule

/* rtl/setting_journal_controller.sv */
// setting_journal_controller
//
// Keeps one profile setting in an append-only journal of checksummed flash
// records. Input words arrive on item/item_valid/item_stall: scan records at
// start-up, set requests, time ticks and write readbacks. Each accepted word
// gives exactly one result word on result/result_valid/result_stall.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. Indexes beyond the register list are ignored.
//
// Each word runs its 12 record bytes through a byte-serial FNV-1a unit, one
// byte per cycle; no new word is taken until the previous result is loaded.
// The result sits in an output register: item_stall drops again as soon as
// the result is loaded, even while result_stall holds it. A finished word
// waits in place when the previous result has not yet been taken.
// rst (synchronous) clears all journal state and loads the register
// defaults; no result is pending after reset.
module setting_journal_controller #(
  parameter int RECORD_SLOTS = sjc_pkg::RECORD_SLOTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  sjc_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output sjc_pkg::result_t                   result,
  input  logic                               cfg_we,
  input  logic [sjc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sjc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW = $clog2(RECORD_SLOTS + 1);
  localparam logic [SW-1:0] SLOTS = SW'(RECORD_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HASH = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [7:0] backup_profile;
  logic [7:0] default_profile;
  logic [7:0] max_profile;
  logic store_enabled;
  logic [15:0] save_delay_ms;

  // journal state
  logic [7:0] active_profile, active_profile_next;
  logic profile_known, profile_known_next;
  logic [31:0] last_sequence, last_sequence_next;
  logic found_any, found_any_next;
  logic [SW-1:0] scan_slot, scan_slot_next;
  logic scan_done, scan_done_next;
  logic [SW-1:0] next_free_slot, next_free_slot_next;
  logic pending, pending_next;
  logic [31:0] pending_start, pending_start_next;
  logic awaiting_readback, awaiting_readback_next;
  logic [SW-1:0] issued_slot, issued_slot_next;
  logic [31:0] issued_sequence, issued_sequence_next;
  logic [7:0] issued_profile, issued_profile_next;

  sjc_pkg::item_t held;
  sjc_pkg::result_t result_next;

  logic accept;
  logic commit;
  logic [sjc_pkg::MSG_W-1:0] msg;
  logic [31:0] hash;
  sjc_pkg::fnv_status_t fnv_status;

  logic [7:0] tick_profile;
  logic [31:0] tick_sequence;
  logic rec_ok;
  logic [31:0] seq_diff;
  logic [31:0] age;
  logic [SW-1:0] scan_slot_inc;
  logic [SW-1:0] wslot;
  logic full;

  assign accept = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign commit = (state == S_DONE) && (!result_valid || !result_stall);

  // record bytes, little endian; a tick hashes the record it will write
  assign tick_profile = active_profile;
  assign tick_sequence = last_sequence + 32'd1;

  always_comb begin
    if (item.opcode == sjc_pkg::OP_TICK) begin
      msg = {8'd0, ~tick_profile, tick_profile, sjc_pkg::REC_VERSION,
             tick_sequence, sjc_pkg::REC_MAGIC};
    end else begin
      msg = {item.rec_reserved, item.rec_inverse, item.rec_profile, item.rec_version,
             item.rec_sequence, item.rec_magic};
    end
  end

  sjc_fnv u_fnv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .msg    (msg),
    .hash   (hash),
    .status (fnv_status)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (fnv_status.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rec_ok = (held.rec_magic == sjc_pkg::REC_MAGIC) &&
                  (held.rec_version == sjc_pkg::REC_VERSION) &&
                  (held.rec_inverse == ~held.rec_profile) &&
                  (held.rec_profile <= max_profile) &&
                  (held.rec_checksum == hash);
  assign seq_diff = held.rec_sequence - last_sequence;
  assign age = held.now_ms - pending_start;
  assign scan_slot_inc = scan_slot + SW'(1);
  assign full = (next_free_slot >= SLOTS);
  assign wslot = full ? '0 : next_free_slot;

  always_comb begin
    active_profile_next = active_profile;
    profile_known_next = profile_known;
    last_sequence_next = last_sequence;
    found_any_next = found_any;
    scan_slot_next = scan_slot;
    scan_done_next = scan_done;
    next_free_slot_next = next_free_slot;
    pending_next = pending;
    pending_start_next = pending_start;
    awaiting_readback_next = awaiting_readback;
    issued_slot_next = issued_slot;
    issued_sequence_next = issued_sequence;
    issued_profile_next = issued_profile;
    result_next = '0;

    if (held.opcode != sjc_pkg::OP_SCAN) begin
      scan_done_next = 1'b1;
    end

    unique case (held.opcode)
      sjc_pkg::OP_SCAN: begin
        if (store_enabled && !scan_done) begin
          if (held.rec_magic == sjc_pkg::REC_ERASED) begin
            next_free_slot_next = scan_slot;
            scan_done_next = 1'b1;
          end else begin
            result_next.record_valid = rec_ok;
            next_free_slot_next = scan_slot_inc;
            if (rec_ok && (!found_any || (seq_diff != 32'd0 && !seq_diff[31]))) begin
              found_any_next = 1'b1;
              last_sequence_next = held.rec_sequence;
              active_profile_next = held.rec_profile;
              profile_known_next = 1'b1;
            end
            scan_slot_next = scan_slot_inc;
            if (scan_slot_inc >= SLOTS) begin
              scan_done_next = 1'b1;
            end
          end
        end
      end
      sjc_pkg::OP_SET: begin
        if (store_enabled && (held.requested_profile <= max_profile)) begin
          active_profile_next = held.requested_profile;
          profile_known_next = 1'b1;
          pending_start_next = held.now_ms;
          pending_next = 1'b1;
        end
      end
      sjc_pkg::OP_TICK: begin
        if (pending && !awaiting_readback && (age >= {16'd0, save_delay_ms})) begin
          result_next.write_request = 1'b1;
          result_next.write_slot = 4'(wslot);
          result_next.write_erase = full;
          result_next.write_sequence = tick_sequence;
          result_next.write_checksum = hash;
          awaiting_readback_next = 1'b1;
          issued_slot_next = wslot;
          issued_sequence_next = tick_sequence;
          issued_profile_next = active_profile;
        end
      end
      sjc_pkg::OP_READBACK: begin
        if (awaiting_readback) begin
          awaiting_readback_next = 1'b0;
          if (held.flash_ok && rec_ok && (held.rec_sequence == issued_sequence) &&
              (held.rec_profile == issued_profile)) begin
            result_next.record_valid = 1'b1;
            last_sequence_next = issued_sequence;
            found_any_next = 1'b1;
            next_free_slot_next = issued_slot + SW'(1);
            if (active_profile == issued_profile) begin
              pending_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase

    if (profile_known_next) begin
      result_next.current_profile = active_profile_next;
    end else if (backup_profile <= max_profile) begin
      result_next.current_profile = backup_profile;
    end else begin
      result_next.current_profile = default_profile;
    end
    result_next.save_pending = pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      result_valid <= 1'b0;
      active_profile <= '0;
      profile_known <= 1'b0;
      last_sequence <= '0;
      found_any <= 1'b0;
      scan_slot <= '0;
      scan_done <= 1'b0;
      next_free_slot <= '0;
      pending <= 1'b0;
      pending_start <= '0;
      awaiting_readback <= 1'b0;
      issued_slot <= '0;
      issued_sequence <= '0;
      issued_profile <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        result_valid <= 1'b1;
        active_profile <= active_profile_next;
        profile_known <= profile_known_next;
        last_sequence <= last_sequence_next;
        found_any <= found_any_next;
        scan_slot <= scan_slot_next;
        scan_done <= scan_done_next;
        next_free_slot <= next_free_slot_next;
        pending <= pending_next;
        pending_start <= pending_start_next;
        awaiting_readback <= awaiting_readback_next;
        issued_slot <= issued_slot_next;
        issued_sequence <= issued_sequence_next;
        issued_profile <= issued_profile_next;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= item;
    end
    if (commit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      backup_profile <= sjc_pkg::FALLBACK_RESET;
      default_profile <= sjc_pkg::DEFAULT_RESET;
      max_profile <= sjc_pkg::MAX_PROFILE_RESET;
      store_enabled <= sjc_pkg::STORE_ENABLED_RESET;
      save_delay_ms <= sjc_pkg::SAVE_DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sjc_pkg::REG_FALLBACK:      backup_profile <= cfg_data[7:0];
        sjc_pkg::REG_DEFAULT:       default_profile <= cfg_data[7:0];
        sjc_pkg::REG_MAX_PROFILE:   max_profile <= cfg_data[7:0];
        sjc_pkg::REG_STORE_ENABLED: store_enabled <= cfg_data[0];
        sjc_pkg::REG_SAVE_DELAY:    save_delay_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
